>>> hdl/dcd_pkg.sv
// Shared types and constants of the directed cycle detector.
`default_nettype none

package dcd_pkg;

  localparam int unsigned NODES_DEF = 64;

  localparam int unsigned NCOUNT_W = 7;
  localparam logic [NCOUNT_W-1:0] NCOUNT_RST = 7'd64;

  localparam int unsigned OP_W = 2;
  localparam int unsigned NODE_FIELD_W = 6;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef struct packed {
    logic clr;
    logic rd_en;
    logic wr_en;
  } adj_ctrl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } stk_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/dcd_adj_store.sv
// Adjacency matrix memory with per-row valid bits and registered read.
`default_nettype none

module dcd_adj_store import dcd_pkg::*; #(
  parameter int unsigned Nodes = NODES_DEF,
  localparam int unsigned NW = $clog2(Nodes)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire adj_ctrl_t        ctrl_i,
  input  wire logic [NW-1:0]    rd_addr_i,
  input  wire logic [NW-1:0]    wr_addr_i,
  input  wire logic [Nodes-1:0] wr_data_i,
  output logic      [Nodes-1:0] rd_data_o
);

  logic [Nodes-1:0] mem [Nodes];
  logic [Nodes-1:0] rd_data_q;
  logic [Nodes-1:0] row_valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        row_valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hdl/dcd_frame_stack.sv
// Depth-first search stack of saved (node, next neighbor) frames.
`default_nettype none

module dcd_frame_stack import dcd_pkg::*; #(
  parameter int unsigned Nodes = NODES_DEF,
  localparam int unsigned NW = $clog2(Nodes),
  localparam int unsigned CW = $clog2(Nodes + 1)
) (
  input  wire logic          clk_i,
  input  wire stk_ctrl_t     ctrl_i,
  input  wire logic [NW-1:0] wr_addr_i,
  input  wire logic [NW-1:0] rd_addr_i,
  input  wire logic [NW-1:0] wr_node_i,
  input  wire logic [CW-1:0] wr_next_i,
  output logic      [NW-1:0] rd_node_o,
  output logic      [CW-1:0] rd_next_o
);

  logic [NW+CW-1:0] mem [Nodes];
  logic [NW+CW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= {wr_node_i, wr_next_i};
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_node_o = rd_q[NW+CW-1:CW];
  assign rd_next_o = rd_q[CW-1:0];

endmodule

`default_nettype wire

>>> hdl/directed_cycle_detector_unit.sv
// Clear is done on acceptance; add edge reads the row, then writes it back. A
// check walks every adjacency row once for the N nodes in use, one neighbor
// test per cycle, plus one row or stack read per descent and return.
// A check also waits in its done state while the previous result is still held.
// The block takes one transaction at a time and is not ready while it works.
// Reset empties the adjacency store at once through its row valid bits and sets
// the node count to 64.
`default_nettype none

module directed_cycle_detector_unit import dcd_pkg::*; #(
  parameter int unsigned NODES = NODES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // operation [1:0], from_node [7:2], to_node [13:8], zero [15:14]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // is_acyclic [0], zero [7:1]
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [NCOUNT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ADD_WR = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_POP    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [NCOUNT_W-1:0]   ncount_q, ncount_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         r_q, r_d;
  logic [NW-1:0]         u_q, u_d;
  logic [CW-1:0]         v_q, v_d;
  logic [CW-1:0]         depth_q, depth_d;
  logic [NW-1:0]         to_q, to_d;
  logic [NW-1:0]         from_q, from_d;
  logic [NODES-1:0]      visited_q, visited_d;
  logic [NODES-1:0]      onstack_q, onstack_d;
  logic                  result_q, result_d;
  logic                  mvalid_q, mvalid_d;
  logic                  mdata_q, mdata_d;

  op_e                   op;
  logic [NODE_FIELD_W-1:0] from_f, to_f;
  logic                  accept;
  logic                  edge_ok;
  logic [CW-1:0]         cnt_sat;
  logic [NW-1:0]         w;
  logic [NW-1:0]         r_idx;
  logic [CW-1:0]         depth_m1;
  logic [NODES-1:0]      to_bit;

  adj_ctrl_t             adj_ctrl;
  logic [NW-1:0]         adj_rd_addr;
  logic [NODES-1:0]      adj_row;
  stk_ctrl_t             stk_ctrl;
  logic [NW-1:0]         stk_rd_addr;
  logic [NW-1:0]         stk_rd_node;
  logic [CW-1:0]         stk_rd_next;

  assign op      = op_e'(s_axis_tdata_i[1:0]);
  assign from_f  = s_axis_tdata_i[7:2];
  assign to_f    = s_axis_tdata_i[13:8];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign edge_ok = (32'(from_f) < NODES) && (32'(to_f) < NODES);
  assign cnt_sat = (32'(ncount_q) > NODES) ? CW'(NODES) : CW'(ncount_q);
  assign w        = v_q[NW-1:0];
  assign r_idx    = r_q[NW-1:0];
  assign depth_m1 = depth_q - 1'b1;
  assign to_bit   = {{(NODES-1){1'b0}}, 1'b1} << to_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-1){1'b0}}, mdata_q};

  dcd_adj_store #(
    .Nodes(NODES)
  ) u_adj_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (adj_ctrl),
    .rd_addr_i(adj_rd_addr),
    .wr_addr_i(from_q),
    .wr_data_i(adj_row | to_bit),
    .rd_data_o(adj_row)
  );

  dcd_frame_stack #(
    .Nodes(NODES)
  ) u_frame_stack (
    .clk_i    (clk_i),
    .ctrl_i   (stk_ctrl),
    .wr_addr_i(depth_q[NW-1:0]),
    .rd_addr_i(stk_rd_addr),
    .wr_node_i(u_q),
    .wr_next_i(v_q + 1'b1),
    .rd_node_o(stk_rd_node),
    .rd_next_o(stk_rd_next)
  );

  always_comb begin
    state_d     = state_q;
    ncount_d    = cfg_we_i ? cfg_wdata_i : ncount_q;
    cnt_d       = cnt_q;
    r_d         = r_q;
    u_d         = u_q;
    v_d         = v_q;
    depth_d     = depth_q;
    to_d        = to_q;
    from_d      = from_q;
    visited_d   = visited_q;
    onstack_d   = onstack_q;
    result_d    = result_q;
    mvalid_d    = mvalid_q && !m_axis_tready_i;
    mdata_d     = mdata_q;
    adj_ctrl    = '0;
    adj_rd_addr = '0;
    stk_ctrl    = '0;
    stk_rd_addr = depth_m1[NW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_CLEAR: begin
              adj_ctrl.clr = 1'b1;
            end
            OP_ADD: begin
              if (edge_ok) begin
                adj_ctrl.rd_en = 1'b1;
                adj_rd_addr    = NW'(from_f);
                from_d         = NW'(from_f);
                to_d           = NW'(to_f);
                state_d        = ST_ADD_WR;
              end
            end
            OP_CHECK: begin
              visited_d = '0;
              onstack_d = '0;
              depth_d   = '0;
              r_d       = '0;
              cnt_d     = cnt_sat;
              state_d   = ST_ROOT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        adj_ctrl.wr_en = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_ROOT: begin
        if (r_q == cnt_q) begin
          result_d = 1'b1;
          state_d  = ST_DONE;
        end else if (visited_q[r_idx]) begin
          r_d = r_q + 1'b1;
        end else begin
          u_d               = r_idx;
          v_d               = '0;
          visited_d[r_idx]  = 1'b1;
          onstack_d[r_idx]  = 1'b1;
          adj_ctrl.rd_en    = 1'b1;
          adj_rd_addr       = r_idx;
          state_d           = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (v_q == cnt_q) begin
          onstack_d[u_q] = 1'b0;
          if (depth_q == '0) begin
            state_d = ST_ROOT;
          end else begin
            stk_ctrl.rd_en = 1'b1;
            depth_d        = depth_m1;
            state_d        = ST_POP;
          end
        end else if (adj_row[w] && onstack_q[w]) begin
          result_d = 1'b0;
          state_d  = ST_DONE;
        end else if (adj_row[w] && !visited_q[w]) begin
          stk_ctrl.wr_en = 1'b1;
          depth_d        = depth_q + 1'b1;
          u_d            = w;
          v_d            = '0;
          visited_d[w]   = 1'b1;
          onstack_d[w]   = 1'b1;
          adj_ctrl.rd_en = 1'b1;
          adj_rd_addr    = w;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      ST_POP: begin
        u_d            = stk_rd_node;
        v_d            = stk_rd_next;
        adj_ctrl.rd_en = 1'b1;
        adj_rd_addr    = stk_rd_node;
        state_d        = ST_SCAN;
      end
      ST_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = result_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ncount_q  <= NCOUNT_RST;
      cnt_q     <= '0;
      r_q       <= '0;
      depth_q   <= '0;
      visited_q <= '0;
      onstack_q <= '0;
      mvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ncount_q  <= ncount_d;
      cnt_q     <= cnt_d;
      r_q       <= r_d;
      depth_q   <= depth_d;
      visited_q <= visited_d;
      onstack_q <= onstack_d;
      mvalid_q  <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q      <= u_d;
    v_q      <= v_d;
    to_q     <= to_d;
    from_q   <= from_d;
    result_q <= result_d;
    mdata_q  <= mdata_d;
  end

  // A node is only ever on the stack after it has been visited.
  a_onstack_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (onstack_q & ~visited_q) == '0)
    else $error("on-stack mark set on an unvisited node");

  // The current frame plus the saved frames are exactly the nodes on the stack.
  a_stack_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_POP) |->
      ($countones(onstack_q) == int'(depth_q) + 1))
    else $error("stack depth disagrees with on-stack marks");

  // While scanning, the current node is on the stack and the scan stays in range.
  a_scan_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (onstack_q[u_q] && (v_q <= cnt_q) && (depth_q < cnt_q)))
    else $error("scan frame out of range");

  // A result is loaded only when leaving the done state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

endmodule

`default_nettype wire
